FILE: hdl/dat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dat_pkg
// Shared types and codes of the deadline-aware task dispatcher.
// ----------------------------------------------------------------------------
package dat_pkg;

  localparam int unsigned MAX_NEIGHBORS_DEF = 8;
  localparam int unsigned MAX_SUBTASKS_DEF  = 16;

  // time budget is slack (48 bits) times cycles per tick (32 bits)
  localparam int unsigned BUDGET_W = 80;
  // pending cycles plus up to 64 subtasks of 40 bits
  localparam int unsigned ACC_W    = 47;

  localparam logic [1:0] FUNC_LOAD_NBR = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SUB = 2'd1;
  localparam logic [1:0] FUNC_DISPATCH = 2'd2;
  localparam logic [1:0] FUNC_REPORT   = 2'd3;

  localparam logic [2:0] ACT_LOCAL_WHOLE   = 3'd0;
  localparam logic [2:0] ACT_OFFLOAD_WHOLE = 3'd1;
  localparam logic [2:0] ACT_DROP          = 3'd2;
  localparam logic [2:0] ACT_LOCAL_PART    = 3'd3;
  localparam logic [2:0] ACT_OFFLOAD_PART  = 3'd4;
  localparam logic [2:0] ACT_DROP_REPORT   = 3'd5;

  localparam logic [1:0] CFG_OWN_ID = 2'd0;
  localparam logic [1:0] CFG_CPT    = 2'd1;
  localparam logic [1:0] CFG_SPLIT  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  neighbor_id;
    logic [31:0] neighbor_space;
    logic [31:0] subtask_size;
    logic [39:0] subtask_cycles;
    logic [47:0] now_time;
    logic [47:0] deadline_time;
    logic [31:0] local_space;
    logic [39:0] local_pending_cycles;
    logic [31:0] task_size;
    logic [39:0] task_cycles;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  destination_server;
    logic [31:0] part_size;
    logic [39:0] part_cycles;
    logic [31:0] drop_count;
    logic        last;
  } out_item_t;

endpackage

FILE: hdl/deadline_aware_task_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_aware_task_dispatcher
// Collects neighbour and subtask entries, then dispatches a task locally,
// whole to a neighbour, or split part by part; late tasks are dropped and counted.
// ----------------------------------------------------------------------------
// channel  | direction | handshake             | payload
// in       | input     | in_valid_i/in_ready_o | in_data_i   (dat_pkg::in_item_t)
// out      | output    | out_valid_o/out_ready_i | out_data_o (dat_pkg::out_item_t)
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a load is taken in the idle state; a report or a drop goes straight to the
// emit state. a dispatch passes the multiply, sum and decide states, and a
// whole offload adds one neighbour memory sweep. a split dispatch takes per
// part one subtask memory sweep, a step to pick the part, for offloaded parts
// one neighbour memory sweep, and a hand-off to the output register.
// reset clears counters and control; the tables need no clearing pass.
// the output register decouples a stalled consumer: loads are still taken while it holds an item.
// ----------------------------------------------------------------------------
module deadline_aware_task_dispatcher #(
  parameter int unsigned MaxNeighbors = dat_pkg::MAX_NEIGHBORS_DEF,
  parameter int unsigned MaxSubtasks  = dat_pkg::MAX_SUBTASKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dat_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dat_pkg::out_item_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned CntNW = $clog2(MaxNeighbors + 1);
  localparam int unsigned CntSW = $clog2(MaxSubtasks + 1);
  localparam int unsigned AddrNW = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
  localparam int unsigned AddrSW = (MaxSubtasks > 1) ? $clog2(MaxSubtasks) : 1;
  localparam int unsigned CntW = (CntNW > CntSW) ? CntNW : CntSW;
  localparam int unsigned BW = dat_pkg::BUDGET_W;
  localparam int unsigned AW = dat_pkg::ACC_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_SSCAN = 8'b0001_0000,
    S_PART  = 8'b0010_0000,
    S_NSCAN = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  dat_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [7:0]  own_id_q;
  logic [31:0] cpt_q;
  logic        split_q;

  logic [CntNW-1:0] ncount_q, ncount_d;
  logic [CntSW-1:0] scount_q, scount_d;
  logic [31:0]      drops_q, drops_d;

  logic [47:0] slack_q, slack_d;
  logic [31:0] lspace_q, lspace_d;
  logic [39:0] pend_q, pend_d;
  logic [31:0] tsize_q, tsize_d;
  logic [39:0] tcyc_q, tcyc_d;

  logic [MaxSubtasks-1:0] chosen_q, chosen_d;
  logic [CntSW-1:0] k_q, k_d;
  logic [31:0]      space_q, space_d;
  logic [AW-1:0]    acc_q, acc_d;
  logic             local_q, local_d;
  logic             part_mode_q, part_mode_d;

  logic [CntW-1:0] rd_cnt_q, rd_cnt_d, ridx_q, ridx_d;
  logic            rv_q, rv_d;

  logic              sb_found_q, sb_found_d;
  logic [CntW-1:0]   sb_idx_q, sb_idx_d;
  logic [31:0]       sb_sz_q, sb_sz_d;
  logic [39:0]       sb_cy_q, sb_cy_d;

  logic              nb_found_q, nb_found_d;
  logic [CntW-1:0]   nb_idx_q, nb_idx_d;
  logic [39:0]       nb_free_q, nb_free_d;
  logic [7:0]        nb_id_q, nb_id_d;

  logic [BW-1:0] budget;
  logic [71:0]   sub_rdata, sub_wdata;
  logic [47:0]   nbr_rdata, nbr_wdata;
  logic          sub_we, nbr_we;
  logic [AddrNW-1:0] nbr_waddr;
  logic          in_acc;
  logic          last_part;
  logic [AW-1:0] acc_next;
  logic [40:0]   whole_work;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign last_part  = (k_q == scount_q - CntSW'(1));
  assign acc_next   = acc_q + AW'(sb_cy_q);
  assign whole_work = {1'b0, pend_q} + {1'b0, tcyc_q};

  dat_budget u_budget (
    .clk_i,
    .slack_i  (slack_q),
    .cpt_i    (cpt_q),
    .budget_o (budget)
  );

  assign sub_we = in_acc && (in_data_i.func == dat_pkg::FUNC_LOAD_SUB)
                  && (scount_q < CntSW'(MaxSubtasks));
  assign sub_wdata = {in_data_i.subtask_size, in_data_i.subtask_cycles};

  dat_ram #(.Width(72), .Depth(MaxSubtasks)) u_sub_ram (
    .clk_i,
    .we_i    (sub_we),
    .waddr_i (scount_q[AddrSW-1:0]),
    .wdata_i (sub_wdata),
    .raddr_i (rd_cnt_q[AddrSW-1:0]),
    .rdata_o (sub_rdata)
  );

  // neighbour write port: loads while idle, debit at the end of a part scan
  always_comb begin
    nbr_we    = 1'b0;
    nbr_waddr = ncount_q[AddrNW-1:0];
    nbr_wdata = {in_data_i.neighbor_id, 8'd0, in_data_i.neighbor_space};
    if (in_acc && (in_data_i.func == dat_pkg::FUNC_LOAD_NBR)
        && (ncount_q < CntNW'(MaxNeighbors))) begin
      nbr_we = 1'b1;
    end else if ((state_q == S_NSCAN) && (rd_cnt_q == CntW'(ncount_q)) && !rv_q
                 && part_mode_q && nb_found_q) begin
      nbr_we    = 1'b1;
      nbr_waddr = nb_idx_q[AddrNW-1:0];
      nbr_wdata = {nb_id_q, nb_free_q - {8'd0, sb_sz_q}};
    end
  end

  dat_ram #(.Width(48), .Depth(MaxNeighbors)) u_nbr_ram (
    .clk_i,
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (nbr_wdata),
    .raddr_i (rd_cnt_q[AddrNW-1:0]),
    .rdata_o (nbr_rdata)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    res_d       = res_q;
    ncount_d    = ncount_q;
    scount_d    = scount_q;
    drops_d     = drops_q;
    slack_d     = slack_q;
    lspace_d    = lspace_q;
    pend_d      = pend_q;
    tsize_d     = tsize_q;
    tcyc_d      = tcyc_q;
    chosen_d    = chosen_q;
    k_d         = k_q;
    space_d     = space_q;
    acc_d       = acc_q;
    local_d     = local_q;
    part_mode_d = part_mode_q;
    rd_cnt_d    = rd_cnt_q;
    ridx_d      = ridx_q;
    rv_d        = 1'b0;
    sb_found_d  = sb_found_q;
    sb_idx_d    = sb_idx_q;
    sb_sz_d     = sb_sz_q;
    sb_cy_d     = sb_cy_q;
    nb_found_d  = nb_found_q;
    nb_idx_d    = nb_idx_q;
    nb_free_d   = nb_free_q;
    nb_id_d     = nb_id_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.func)
            dat_pkg::FUNC_LOAD_NBR: begin
              if (ncount_q < CntNW'(MaxNeighbors)) ncount_d = ncount_q + CntNW'(1);
            end
            dat_pkg::FUNC_LOAD_SUB: begin
              if (scount_q < CntSW'(MaxSubtasks)) scount_d = scount_q + CntSW'(1);
            end
            dat_pkg::FUNC_REPORT: begin
              res_d.action             = dat_pkg::ACT_DROP_REPORT;
              res_d.destination_server = '0;
              res_d.part_size          = '0;
              res_d.part_cycles        = '0;
              res_d.drop_count         = drops_q;
              res_d.last               = 1'b1;
              drops_d = '0;
              ret_d   = S_IDLE;
              state_d = S_EMIT;
            end
            dat_pkg::FUNC_DISPATCH: begin
              slack_d  = in_data_i.deadline_time - in_data_i.now_time;
              lspace_d = in_data_i.local_space;
              pend_d   = in_data_i.local_pending_cycles;
              tsize_d  = in_data_i.task_size;
              tcyc_d   = in_data_i.task_cycles;
              if (in_data_i.now_time > in_data_i.deadline_time) begin
                drops_d = (drops_q != '1) ? drops_q + 32'd1 : drops_q;
                res_d.action             = dat_pkg::ACT_DROP;
                res_d.destination_server = own_id_q;
                res_d.part_size          = in_data_i.task_size;
                res_d.part_cycles        = in_data_i.task_cycles;
                res_d.drop_count         = drops_d;
                res_d.last               = 1'b1;
                ncount_d = '0;
                scount_d = '0;
                ret_d    = S_IDLE;
                state_d  = S_EMIT;
              end else begin
                state_d = S_MUL;
              end
            end
          endcase
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_DEC;
      S_DEC: begin
        rd_cnt_d   = '0;
        sb_found_d = 1'b0;
        nb_found_d = 1'b0;
        if ((lspace_q >= tsize_q) && (BW'(whole_work) <= budget)) begin
          res_d.action             = dat_pkg::ACT_LOCAL_WHOLE;
          res_d.destination_server = own_id_q;
          res_d.part_size          = tsize_q;
          res_d.part_cycles        = tcyc_q;
          res_d.drop_count         = drops_q;
          res_d.last               = 1'b1;
          ncount_d = '0;
          scount_d = '0;
          ret_d    = S_IDLE;
          state_d  = S_EMIT;
        end else if (!split_q || (scount_q <= CntSW'(1))) begin
          part_mode_d = 1'b0;
          state_d     = S_NSCAN;
        end else begin
          chosen_d = '0;
          k_d      = '0;
          space_d  = lspace_q;
          acc_d    = AW'(pend_q);
          local_d  = 1'b1;
          state_d  = S_SSCAN;
        end
      end
      S_SSCAN: begin
        if (rd_cnt_q < CntW'(scount_q)) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
          ridx_d   = rd_cnt_q;
          rv_d     = 1'b1;
        end
        // strict compare keeps load order among equal sizes
        if (rv_q && !chosen_q[ridx_q[AddrSW-1:0]]
            && (!sb_found_q || (sub_rdata[71:40] > sb_sz_q))) begin
          sb_found_d = 1'b1;
          sb_idx_d   = ridx_q;
          sb_sz_d    = sub_rdata[71:40];
          sb_cy_d    = sub_rdata[39:0];
        end
        if ((rd_cnt_q == CntW'(scount_q)) && !rv_q) state_d = S_PART;
      end
      S_PART: begin
        chosen_d[sb_idx_q[AddrSW-1:0]] = 1'b1;
        rd_cnt_d   = '0;
        sb_found_d = 1'b0;
        nb_found_d = 1'b0;
        if (local_q && (space_q >= sb_sz_q) && (BW'(acc_next) <= budget)) begin
          res_d.action             = dat_pkg::ACT_LOCAL_PART;
          res_d.destination_server = own_id_q;
          res_d.part_size          = sb_sz_q;
          res_d.part_cycles        = sb_cy_q;
          res_d.drop_count         = drops_q;
          res_d.last               = last_part;
          space_d = space_q - sb_sz_q;
          acc_d   = acc_next;
          k_d     = k_q + CntSW'(1);
          if (last_part) begin
            ncount_d = '0;
            scount_d = '0;
            ret_d    = S_IDLE;
          end else begin
            ret_d = S_SSCAN;
          end
          state_d = S_EMIT;
        end else begin
          local_d     = 1'b0;
          part_mode_d = 1'b1;
          state_d     = S_NSCAN;
        end
      end
      S_NSCAN: begin
        if (rd_cnt_q < CntW'(ncount_q)) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
          ridx_d   = rd_cnt_q;
          rv_d     = 1'b1;
        end
        // lowest slot wins among equal free space
        if (rv_q && (!nb_found_q || ($signed(nbr_rdata[39:0]) > $signed(nb_free_q)))) begin
          nb_found_d = 1'b1;
          nb_idx_d   = ridx_q;
          nb_free_d  = nbr_rdata[39:0];
          nb_id_d    = nbr_rdata[47:40];
        end
        if ((rd_cnt_q == CntW'(ncount_q)) && !rv_q) begin
          res_d.destination_server = nb_found_q ? nb_id_q : own_id_q;
          res_d.drop_count         = drops_q;
          rd_cnt_d   = '0;
          sb_found_d = 1'b0;
          nb_found_d = 1'b0;
          if (part_mode_q) begin
            res_d.action      = dat_pkg::ACT_OFFLOAD_PART;
            res_d.part_size   = sb_sz_q;
            res_d.part_cycles = sb_cy_q;
            res_d.last        = last_part;
            k_d = k_q + CntSW'(1);
            if (last_part) begin
              ncount_d = '0;
              scount_d = '0;
              ret_d    = S_IDLE;
            end else begin
              ret_d = S_SSCAN;
            end
          end else begin
            res_d.action      = dat_pkg::ACT_OFFLOAD_WHOLE;
            res_d.part_size   = tsize_q;
            res_d.part_cycles = tcyc_q;
            res_d.last        = 1'b1;
            ncount_d = '0;
            scount_d = '0;
            ret_d    = S_IDLE;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      own_id_q    <= '0;
      cpt_q       <= 32'd1;
      split_q     <= 1'b1;
      ncount_q    <= '0;
      scount_q    <= '0;
      drops_q     <= '0;
      chosen_q    <= '0;
      k_q         <= '0;
      local_q     <= 1'b0;
      part_mode_q <= 1'b0;
      rd_cnt_q    <= '0;
      rv_q        <= 1'b0;
      sb_found_q  <= 1'b0;
      nb_found_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      ncount_q    <= ncount_d;
      scount_q    <= scount_d;
      drops_q     <= drops_d;
      chosen_q    <= chosen_d;
      k_q         <= k_d;
      local_q     <= local_d;
      part_mode_q <= part_mode_d;
      rd_cnt_q    <= rd_cnt_d;
      rv_q        <= rv_d;
      sb_found_q  <= sb_found_d;
      nb_found_q  <= nb_found_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          dat_pkg::CFG_OWN_ID: own_id_q <= cfg_data_i[7:0];
          dat_pkg::CFG_CPT:    cpt_q    <= cfg_data_i;
          dat_pkg::CFG_SPLIT:  split_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    out_q     <= out_d;
    slack_q   <= slack_d;
    lspace_q  <= lspace_d;
    pend_q    <= pend_d;
    tsize_q   <= tsize_d;
    tcyc_q    <= tcyc_d;
    space_q   <= space_d;
    acc_q     <= acc_d;
    ridx_q    <= ridx_d;
    sb_idx_q  <= sb_idx_d;
    sb_sz_q   <= sb_sz_d;
    sb_cy_q   <= sb_cy_d;
    nb_idx_q  <= nb_idx_d;
    nb_free_q <= nb_free_d;
    nb_id_q   <= nb_id_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_part_has_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PART) |-> sb_found_q) else $error("part step without a subtask");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && res_q.last) |-> (ret_q == S_IDLE))
    else $error("final item does not end the run");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ncount_q <= CntNW'(MaxNeighbors)) && (scount_q <= CntSW'(MaxSubtasks)))
    else $error("table fill count out of range");

endmodule

FILE: hdl/dat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dat_budget.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dat_budget
// Two-stage multiplier: cycle budget = slack ticks times cycles per tick.
// ----------------------------------------------------------------------------
module dat_budget (
  input  logic                          clk_i,
  input  logic [47:0]                   slack_i,
  input  logic [31:0]                   cpt_i,
  output logic [dat_pkg::BUDGET_W-1:0]  budget_o
);

  logic [63:0]                  prod_lo_q;
  logic [47:0]                  prod_hi_q;
  logic [dat_pkg::BUDGET_W-1:0] budget_q;

  // split into a 32x32 and a 16x32 partial product
  always_ff @(posedge clk_i) begin
    prod_lo_q <= slack_i[31:0] * cpt_i;
    prod_hi_q <= slack_i[47:32] * cpt_i;
    budget_q  <= {prod_hi_q, 32'd0} + {16'd0, prod_lo_q};
  end

  assign budget_o = budget_q;

endmodule
